// ===== design/trle_pkg.sv =====
// Package for the TGA run-length pixel decoder.
// Holds register indexes, reset values and packet field masks; no dependencies.
package trle_pkg;

   localparam int MaxBytesPerPixelDefault = 4;
   localparam int PixelCountBitsDefault   = 24;

   localparam int CsrIndexBits = 2;
   localparam int CsrDataBits  = 24;

   localparam logic [CsrIndexBits-1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [CsrIndexBits-1:0] CSR_COMPRESSED_MODE = 2'd1;
   localparam logic [CsrIndexBits-1:0] CSR_TOTAL_PIXELS    = 2'd2;

   localparam logic [2:0]  BytesPerPixelReset  = 3'd3;
   localparam logic        CompressedModeReset = 1'b1;
   localparam logic [23:0] TotalPixelsReset    = 24'd1;

   localparam logic [7:0] RunFlagMask   = 8'h80;
   localparam logic [7:0] PacketLenMask = 8'h7F;

endpackage

// ===== design/tga_rle_pixel_decoder.sv =====
// TGA run-length pixel decoder, top level.
// Depends on trle_pkg for register indexes, reset values and packet masks.
//
//  channel | direction | beat content
//  req_    | in        | tdata[7:0] data_byte
//  rsp_    | out       | tdata: pixel_value, repeat_count; tlast image_done; tuser overrun
//  csr_    | in        | index, data (bytes_per_pixel, compressed_mode, total_pixels)
//
// One byte per cycle while req_tready is high; state is updated in the cycle a byte is taken.
// A result is registered into the output buffer as its pixel's last byte is taken.
// A two-entry output buffer lets req_ flow on while rsp_ stalls, until both entries fill.
// Synchronous reset clears state and output; registers return to their reset values.
// After image completion all bytes are taken and dropped until reset.
module tga_rle_pixel_decoder #(
   parameter int MAX_BYTES_PER_PIXEL = trle_pkg::MaxBytesPerPixelDefault,
   parameter int PIXEL_COUNT_BITS    = trle_pkg::PixelCountBitsDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // data_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [8*MAX_BYTES_PER_PIXEL+7:0]    rsp_tdata,   // pixel_value, repeat_count
   output logic                                rsp_tlast,   // image_done
   output logic                                rsp_tuser,   // overrun
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [trle_pkg::CsrIndexBits-1:0]   csr_index,
   input  logic [trle_pkg::CsrDataBits-1:0]    csr_data
);

   localparam int PixelBits = 8 * MAX_BYTES_PER_PIXEL;
   localparam int PosBits   = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;
   localparam int CntBits   = PIXEL_COUNT_BITS;
   localparam int TotBits   = (CntBits > 24) ? CntBits : 24;
   localparam logic [TotBits-1:0] CountMax = TotBits'((64'd1 << CntBits) - 64'd1);
   localparam logic [2:0] MaxDepth = 3'(MAX_BYTES_PER_PIXEL);

   typedef enum logic [1:0] {
      PHASE_HEADER,
      PHASE_PIXEL,
      PHASE_DONE
   } phase_type;

   typedef struct packed {
      logic [PixelBits-1:0] pixel_value;
      logic [7:0]           repeat_count;
      logic                 image_done;
      logic                 overrun;
   } result_type;

   logic [2:0]  bytes_per_pixel_ff;
   logic        compressed_mode_ff;
   logic [23:0] total_pixels_ff;

   phase_type              phase_ff, phase_in;
   logic                   run_packet_ff, run_packet_in;
   logic [7:0]             left_ff, left_in;
   logic [PosBits-1:0]     pos_ff, pos_in;
   logic [PixelBits-1:0]   acc_ff, acc_in;
   logic [CntBits-1:0]     produced_ff, produced_in;
   logic                   clipped_ff, clipped_in;

   result_type main_ff, skid_ff, result;
   logic       main_valid_ff, skid_valid_ff;
   logic       has_result;

   logic                 accept, pop, push;
   logic [2:0]           depth;
   logic [TotBits-1:0]   total_wide;
   logic [CntBits-1:0]   total_eff, remaining;
   logic [PixelBits-1:0] acc_full;
   logic [7:0]           count;
   logic [7:0]           left_dec;

   assign csr_ready  = 1'b1;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = main_valid_ff && rsp_tready;
   assign push       = accept && has_result;

   always_comb begin
      depth = bytes_per_pixel_ff;
      if (depth == 3'd0) depth = 3'd1;
      if (depth > MaxDepth) depth = MaxDepth;
      total_wide = TotBits'(total_pixels_ff);
      total_eff  = (total_wide > CountMax) ? CntBits'(CountMax) : CntBits'(total_wide);
   end

   always_comb begin
      phase_in      = phase_ff;
      run_packet_in = run_packet_ff;
      left_in       = left_ff;
      pos_in        = pos_ff;
      acc_in        = acc_ff;
      produced_in   = produced_ff;
      clipped_in    = clipped_ff;
      has_result    = 1'b0;
      remaining     = total_eff - produced_ff;
      acc_full      = acc_ff | (PixelBits'(req_tdata) << (8 * pos_ff));
      count         = 8'd1;
      left_dec      = (left_ff != 8'd0) ? left_ff - 8'd1 : 8'd0;
      result        = '0;
      if (phase_ff == PHASE_DONE || produced_ff >= total_eff) begin
         // image complete: byte dropped
      end else if (compressed_mode_ff && phase_ff == PHASE_HEADER) begin
         run_packet_in = (req_tdata & trle_pkg::RunFlagMask) != 8'd0;
         left_in       = (req_tdata & trle_pkg::PacketLenMask) + 8'd1;
         pos_in        = '0;
         acc_in        = '0;
         phase_in      = PHASE_PIXEL;
      end else if (3'(pos_ff) + 3'd1 < depth) begin
         acc_in = acc_full;
         pos_in = pos_ff + PosBits'(1);
      end else begin
         has_result = 1'b1;
         pos_in     = '0;
         acc_in     = '0;
         if (!compressed_mode_ff) begin
            count = 8'd1;
         end else if (run_packet_ff) begin
            count = (left_ff == 8'd0) ? 8'd1 : left_ff;
            if (CntBits'(count) > remaining) begin
               count      = 8'(remaining);
               clipped_in = 1'b1;
            end
            left_in  = 8'd0;
            phase_in = PHASE_HEADER;
         end else begin
            count   = 8'd1;
            left_in = left_dec;
            if (remaining == CntBits'(1) && left_dec != 8'd0) clipped_in = 1'b1;
            if (left_dec == 8'd0) phase_in = PHASE_HEADER;
         end
         produced_in = produced_ff + CntBits'(count);
         if (produced_in >= total_eff) begin
            phase_in = PHASE_DONE;
            left_in  = 8'd0;
         end
         result.pixel_value  = acc_full;
         result.repeat_count = count;
         result.image_done   = produced_in >= total_eff;
         result.overrun      = (produced_in >= total_eff) && clipped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_per_pixel_ff <= trle_pkg::BytesPerPixelReset;
         compressed_mode_ff <= trle_pkg::CompressedModeReset;
         total_pixels_ff    <= trle_pkg::TotalPixelsReset;
      end else if (csr_valid) begin
         if (csr_index == trle_pkg::CSR_BYTES_PER_PIXEL) bytes_per_pixel_ff <= csr_data[2:0];
         if (csr_index == trle_pkg::CSR_COMPRESSED_MODE) compressed_mode_ff <= csr_data[0];
         if (csr_index == trle_pkg::CSR_TOTAL_PIXELS)    total_pixels_ff    <= csr_data[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_HEADER;
         run_packet_ff <= 1'b0;
         left_ff       <= 8'd0;
         pos_ff        <= '0;
         acc_ff        <= '0;
         produced_ff   <= '0;
         clipped_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         run_packet_ff <= run_packet_in;
         left_ff       <= left_in;
         pos_ff        <= pos_in;
         acc_ff        <= acc_in;
         produced_ff   <= produced_in;
         clipped_ff    <= clipped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!main_valid_ff || pop) begin
            if (skid_valid_ff) begin
               main_ff       <= skid_ff;
               main_valid_ff <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               main_ff       <= result;
               main_valid_ff <= push;
            end
         end else if (push) begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = {main_ff.repeat_count, main_ff.pixel_value};
   assign rsp_tlast  = main_ff.image_done;
   assign rsp_tuser  = main_ff.overrun;

endmodule

// ===== design/trle_checker.sv =====
// Port-level checker for the TGA run-length pixel decoder, with its bind.
// Depends only on the top level's ports and trle_pkg widths.
module trle_checker #(
   parameter int MAX_BYTES_PER_PIXEL = trle_pkg::MaxBytesPerPixelDefault
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [8*MAX_BYTES_PER_PIXEL+7:0] rsp_tdata,
   input logic                             rsp_tlast,
   input logic                             rsp_tuser
);

   localparam int CountLow = 8 * MAX_BYTES_PER_PIXEL;

   logic [7:0] count;
   assign count = rsp_tdata[CountLow+7:CountLow];

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> count != 8'd0 && count <= 8'd128)
      else $error("repeat count out of range");

   a_overrun_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("overrun on a beat that does not end the image");

endmodule

bind tga_rle_pixel_decoder trle_checker #(
   .MAX_BYTES_PER_PIXEL(MAX_BYTES_PER_PIXEL)
) u_trle_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
